@@ sv/dart_pkg.sv @@
// Shared types, constants and functions of the divider and reload timer.
package dart_pkg;

    localparam int CYCLES_W   = 6;
    localparam int BYTE_W     = 8;
    localparam int PRE_W      = 11;
    localparam int SEL_W      = 2;
    localparam int ADDR_W     = 4;
    localparam int APB_DATA_W = 32;
    localparam int S_TDATA_W  = 8;
    localparam int M_TDATA_W  = 24;

    localparam logic [BYTE_W-1:0] COUNTER_TOP = 8'hFF;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_RELOAD = 2'd0;
    localparam logic [1:0] REG_ENABLE = 2'd1;
    localparam logic [1:0] REG_SELECT = 2'd2;

    localparam logic [SEL_W-1:0] SEL_1024 = 2'd0;
    localparam logic [SEL_W-1:0] SEL_16   = 2'd1;
    localparam logic [SEL_W-1:0] SEL_64   = 2'd2;
    localparam logic [SEL_W-1:0] SEL_256  = 2'd3;

    typedef enum logic [0:0] {
        ST_IDLE,
        ST_RUN
    } dart_state_t;

    typedef struct packed {
        logic load;
        logic step;
        logic publish;
    } dart_cmd_t;

    typedef struct packed {
        logic more;
        logic out_free;
    } dart_sts_t;

    function automatic logic [PRE_W-1:0] period_of(input logic [SEL_W-1:0] sel);
        logic [PRE_W-1:0] p;
        unique case (sel)
            SEL_1024: p = 11'd1024;
            SEL_16:   p = 11'd16;
            SEL_64:   p = 11'd64;
            SEL_256:  p = 11'd256;
            default:  p = 11'd1024;
        endcase
        return p;
    endfunction

endpackage

@@ sv/divider_and_reload_timer_top.sv @@
// Top level of the divider and reload timer: configuration registers and both halves.
// An accepted word is loaded. The step loop then subtracts one period per cycle
// and steps the counter for each whole period in the prescaler (more steps after a
// period was shortened). The result is then published to the output register once
// that register is free. A new word is taken only after the result is published;
// the output register frees the input side for the next word.
// Reset (aresetn low, synchronous) clears registers, prescalers, divider and counter.
module divider_and_reload_timer_top (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [dart_pkg::S_TDATA_W-1:0]    s_tdata,   // [5:0] elapsed_cycles
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [dart_pkg::M_TDATA_W-1:0]    m_tdata,   // [7:0] divider_value,
                                                         // [15:8] counter_value,
                                                         // [16] overflow_irq
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [dart_pkg::ADDR_W-1:0]       paddr,
    input  logic [dart_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [dart_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready
);
    import dart_pkg::*;

    logic [BYTE_W-1:0] reload_reg;
    logic              enable_reg;
    logic [SEL_W-1:0]  select_reg;
    logic              wr_en;
    logic [1:0]        reg_idx;
    dart_cmd_t         cmd;
    dart_sts_t         sts;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            reload_reg <= '0;
            enable_reg <= 1'b0;
            select_reg <= '0;
        end else if (wr_en) begin
            priority case (reg_idx)
                REG_RELOAD: reload_reg <= pwdata[BYTE_W-1:0];
                REG_ENABLE: enable_reg <= pwdata[0];
                REG_SELECT: select_reg <= pwdata[SEL_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        prdata = '0;
        priority case (reg_idx)
            REG_RELOAD: prdata = {24'd0, reload_reg};
            REG_ENABLE: prdata = {31'd0, enable_reg};
            REG_SELECT: prdata = {30'd0, select_reg};
            default:    prdata = '0;
        endcase
    end

    dart_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .sts      (sts),
        .cmd      (cmd)
    );

    dart_dp u_dp (
        .aclk           (aclk),
        .aresetn        (aresetn),
        .cmd            (cmd),
        .sts            (sts),
        .elapsed_cycles (s_tdata[CYCLES_W-1:0]),
        .reload_value   (reload_reg),
        .timer_enable   (enable_reg),
        .clock_select   (select_reg),
        .m_tvalid       (m_tvalid),
        .m_tready       (m_tready),
        .m_tdata        (m_tdata)
    );

endmodule

@@ sv/dart_ctrl.sv @@
// Sequencer of the timer: takes a word, steps the counter once per period, publishes.
module dart_ctrl (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  dart_pkg::dart_sts_t sts,
    output dart_pkg::dart_cmd_t cmd
);
    import dart_pkg::*;

    dart_state_t state_reg;
    dart_state_t state_next;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

    always_comb begin
        state_next  = state_reg;
        s_tready    = 1'b0;
        cmd         = '0;
        unique case (state_reg)
            ST_IDLE: begin
                s_tready = 1'b1;
                if (s_tvalid) begin
                    cmd.load   = 1'b1;
                    state_next = ST_RUN;
                end
            end
            ST_RUN: begin
                priority if (sts.more) begin
                    cmd.step = 1'b1;
                end else if (sts.out_free) begin
                    cmd.publish = 1'b1;
                    state_next  = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

endmodule

@@ sv/dart_dp.sv @@
// Datapath of the timer: prescalers, divider and counter bytes, output register.
module dart_dp (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  dart_pkg::dart_cmd_t                 cmd,
    output dart_pkg::dart_sts_t                 sts,
    input  logic [dart_pkg::CYCLES_W-1:0]       elapsed_cycles,
    input  logic [dart_pkg::BYTE_W-1:0]         reload_value,
    input  logic                                timer_enable,
    input  logic [dart_pkg::SEL_W-1:0]          clock_select,
    output logic                                m_tvalid,
    input  logic                                m_tready,
    output logic [dart_pkg::M_TDATA_W-1:0]      m_tdata
);
    import dart_pkg::*;

    logic [BYTE_W-1:0] div_pre_reg,  div_pre_next;
    logic [BYTE_W-1:0] div_byte_reg, div_byte_next;
    logic [PRE_W-1:0]  cnt_pre_reg,  cnt_pre_next;
    logic [BYTE_W-1:0] cnt_byte_reg, cnt_byte_next;
    logic [PRE_W-1:0]  period_reg,   period_next;
    logic              en_reg,       en_next;
    logic              irq_reg,      irq_next;
    logic              valid_reg,    valid_next;
    logic [M_TDATA_W-1:0] data_reg,  data_next;

    logic [BYTE_W:0]   div_sum;

    assign div_sum      = {1'b0, div_pre_reg} + {{(BYTE_W + 1 - CYCLES_W){1'b0}}, elapsed_cycles};
    assign sts.more     = en_reg && (cnt_pre_reg >= period_reg);
    assign sts.out_free = !valid_reg || m_tready;

    always_comb begin
        div_pre_next  = div_pre_reg;
        div_byte_next = div_byte_reg;
        cnt_pre_next  = cnt_pre_reg;
        cnt_byte_next = cnt_byte_reg;
        period_next   = period_reg;
        en_next       = en_reg;
        irq_next      = irq_reg;
        valid_next    = valid_reg;
        data_next     = data_reg;

        if (cmd.load) begin
            div_pre_next = div_sum[BYTE_W-1:0];
            if (div_sum[BYTE_W]) begin
                div_byte_next = div_byte_reg + 8'd1;
            end
            en_next     = timer_enable;
            period_next = period_of(clock_select);
            irq_next    = 1'b0;
            if (timer_enable) begin
                cnt_pre_next = cnt_pre_reg + {{(PRE_W - CYCLES_W){1'b0}}, elapsed_cycles};
            end
        end

        // One counter increment per whole period held in the prescaler.
        if (cmd.step) begin
            cnt_pre_next = cnt_pre_reg - period_reg;
            if (cnt_byte_reg == COUNTER_TOP) begin
                cnt_byte_next = reload_value;
                irq_next      = 1'b1;
            end else begin
                cnt_byte_next = cnt_byte_reg + 8'd1;
            end
        end

        if (cmd.publish) begin
            valid_next = 1'b1;
            data_next  = {7'd0, irq_reg, cnt_byte_reg, div_byte_reg};
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            div_pre_reg  <= '0;
            div_byte_reg <= '0;
            cnt_pre_reg  <= '0;
            cnt_byte_reg <= '0;
            en_reg       <= 1'b0;
            irq_reg      <= 1'b0;
            valid_reg    <= 1'b0;
        end else begin
            div_pre_reg  <= div_pre_next;
            div_byte_reg <= div_byte_next;
            cnt_pre_reg  <= cnt_pre_next;
            cnt_byte_reg <= cnt_byte_next;
            en_reg       <= en_next;
            irq_reg      <= irq_next;
            valid_reg    <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        period_reg <= period_next;
        data_reg   <= data_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = data_reg;

endmodule

@@ tb/tb_top.sv @@
// Self-checking testbench of the divider and reload timer: stream driver, monitor and predictor.
`timescale 1ns / 100ps

module tb_top;
    import dart_pkg::*;

    localparam int HALF_PERIOD    = 10;
    localparam int RESET_CYCLES   = 4;
    localparam int QUIET_LIMIT    = 5000;
    localparam int PHASE_WORDS    = 95;
    localparam int RANDOM_PHASES  = 10;
    localparam int LONG_HOLD      = 400;
    localparam int SETTLE_CYCLES  = 4;
    localparam int TAIL_CYCLES    = 20;

    typedef enum logic [1:0] {
        IDLE_NONE,
        IDLE_SRC,
        IDLE_SNK,
        IDLE_BOTH
    } idle_mode_t;

    typedef struct {
        logic [BYTE_W-1:0] divider;
        logic [BYTE_W-1:0] counter;
        logic              irq;
    } timer_result_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [S_TDATA_W-1:0]  s_tdata  = '0;
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [M_TDATA_W-1:0]  m_tdata;
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [ADDR_W-1:0]     paddr    = '0;
    logic [APB_DATA_W-1:0] pwdata   = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    divider_and_reload_timer_top u_dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always #HALF_PERIOD aclk = ~aclk;

    // Predictor state and its copy of the registers.
    int                div_prescale = 0;
    int                cnt_prescale = 0;
    logic [BYTE_W-1:0] div_byte     = '0;
    logic [BYTE_W-1:0] cnt_byte     = '0;
    logic [BYTE_W-1:0] cfg_reload   = '0;
    logic              cfg_enable   = 1'b0;
    logic [SEL_W-1:0]  cfg_select   = SEL_1024;

    logic [CYCLES_W-1:0] pending_words[$];
    timer_result_t       expected_results[$];
    timer_result_t       oldest;
    idle_mode_t          idle_mode      = IDLE_NONE;
    int                  words_loaded   = 0;
    int                  results_seen   = 0;
    int                  mismatch_count = 0;
    int                  quiet_cycles   = 0;
    int                  hold_left      = 0;
    bit                  long_hold_req  = 1'b0;
    bit                  word_taken     = 1'b0;

    function automatic timer_result_t advance_timer(input logic [CYCLES_W-1:0] cycles);
        timer_result_t r;
        int            period;
        r.irq = 1'b0;
        div_prescale = div_prescale + int'(cycles);
        while (div_prescale >= 256) begin
            div_prescale = div_prescale - 256;
            div_byte = div_byte + 8'd1;
        end
        if (cfg_enable) begin
            case (cfg_select)
                SEL_1024: period = 1024;
                SEL_16:   period = 16;
                SEL_64:   period = 64;
                default:  period = 256;
            endcase
            // A prescaler left high by a shorter period catches up here.
            cnt_prescale = cnt_prescale + int'(cycles);
            while (cnt_prescale >= period) begin
                cnt_prescale = cnt_prescale - period;
                if (cnt_byte == COUNTER_TOP) begin
                    cnt_byte = cfg_reload;
                    r.irq = 1'b1;
                end else begin
                    cnt_byte = cnt_byte + 8'd1;
                end
            end
        end
        r.divider = div_byte;
        r.counter = cnt_byte;
        return r;
    endfunction

    function automatic bit idles_now(input bit sink_side);
        bit hit;
        hit = 1'b0;
        case (idle_mode)
            IDLE_SRC:  hit = !sink_side && ($urandom_range(99) < 82);
            IDLE_SNK:  hit = sink_side && ($urandom_range(99) < 82);
            IDLE_BOTH: hit = ($urandom_range(99) < 32);
            default:   hit = 1'b0;
        endcase
        return hit;
    endfunction

    function automatic logic [CYCLES_W-1:0] rand_cycles();
        int pick;
        pick = $urandom_range(9);
        if (pick == 0) begin
            return '0;
        end else if (pick == 1) begin
            return '1;
        end
        return CYCLES_W'($urandom_range(63));
    endfunction

    task automatic check_field(input string name, input int want, input int got);
        if (want != got) begin
            $display("%0t: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            mismatch_count++;
        end
    endtask

    task automatic apb_write(input logic [1:0] index, input logic [BYTE_W-1:0] value);
        @(negedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {index, 2'b00};
        pwdata  <= {{(APB_DATA_W-BYTE_W){1'b0}}, value};
        @(negedge aclk);
        penable <= 1'b1;
        do @(posedge aclk); while (!pready);
        case (index)
            REG_RELOAD: cfg_reload = value;
            REG_ENABLE: cfg_enable = value[0];
            REG_SELECT: cfg_select = value[SEL_W-1:0];
            default:    ;
        endcase
        @(negedge aclk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    task automatic push_word(input logic [CYCLES_W-1:0] cycles);
        pending_words.push_back(cycles);
        words_loaded++;
    endtask

    task automatic wait_results();
        wait (results_seen == words_loaded);
        repeat (SETTLE_CYCLES) @(posedge aclk);
    endtask

    // Input driver.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (!s_tvalid || word_taken) begin
            word_taken = 1'b0;
            if (pending_words.size() != 0 && !idles_now(1'b0)) begin
                s_tdata  <= {{(S_TDATA_W-CYCLES_W){1'b0}}, pending_words.pop_front()};
                s_tvalid <= 1'b1;
            end else begin
                s_tvalid <= 1'b0;
            end
        end
    end

    // Result receiver; a long hold-off is counted here.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (long_hold_req) begin
                hold_left = LONG_HOLD;
                long_hold_req = 1'b0;
            end
            if (hold_left > 0) begin
                hold_left--;
                m_tready <= 1'b0;
            end else begin
                m_tready <= !idles_now(1'b1);
            end
        end
    end

    // Monitor: results are checked before the new word is predicted.
    always @(posedge aclk) begin
        if (aresetn) begin
            if (m_tvalid && m_tready) begin
                results_seen++;
                if (expected_results.size() == 0) begin
                    $display("%0t: unexpected result word 0x%06h, expected none", $time, m_tdata);
                    mismatch_count++;
                end else begin
                    oldest = expected_results.pop_front();
                    check_field("divider_value", int'(oldest.divider), int'(m_tdata[7:0]));
                    check_field("counter_value", int'(oldest.counter), int'(m_tdata[15:8]));
                    check_field("overflow_irq", int'(oldest.irq), int'(m_tdata[16]));
                end
            end
            if (s_tvalid && s_tready) begin
                expected_results.push_back(advance_timer(s_tdata[CYCLES_W-1:0]));
                word_taken = 1'b1;
            end
        end
    end

    always @(posedge aclk) begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable)) begin
            quiet_cycles = 0;
        end else begin
            quiet_cycles++;
        end
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t: no handshake for %0d cycles", $time, QUIET_LIMIT);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin
        int                phase;
        logic [BYTE_W-1:0] reload;
        logic [SEL_W-1:0]  sel;

        repeat (RESET_CYCLES) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        // Timer disabled after reset: only the divider moves.
        push_word('0);
        push_word('1);
        push_word(CYCLES_W'(1));
        push_word(CYCLES_W'(42));
        wait_results();

        // Fill the slow prescaler to 1008, then shorten the period.
        apb_write(REG_RELOAD, 8'hFE);
        apb_write(REG_SELECT, BYTE_W'(SEL_1024));
        apb_write(REG_ENABLE, 8'd1);
        idle_mode = IDLE_BOTH;
        repeat (16) push_word('1);
        wait_results();
        apb_write(REG_SELECT, BYTE_W'(SEL_16));
        push_word('1);
        push_word('0);
        wait_results();
        apb_write(REG_ENABLE, 8'd0);
        push_word('1);
        push_word(CYCLES_W'(5));
        wait_results();

        for (phase = 0; phase < RANDOM_PHASES; phase++) begin
            if (phase == 0) begin
                reload = '0;
            end else if (phase == 1) begin
                reload = COUNTER_TOP;
            end else if ($urandom_range(1) != 0) begin
                reload = BYTE_W'($urandom_range(255, 200));
            end else begin
                reload = BYTE_W'($urandom_range(255));
            end
            case (phase)
                0:       sel = SEL_1024;
                1:       sel = SEL_16;
                2:       sel = SEL_64;
                3:       sel = SEL_256;
                default: sel = ($urandom_range(1) != 0) ? SEL_16 : SEL_W'($urandom_range(3));
            endcase
            apb_write(REG_RELOAD, reload);
            apb_write(REG_SELECT, BYTE_W'(sel));
            apb_write(REG_ENABLE, (phase % 5 == 4) ? 8'd0 : 8'd1);
            idle_mode = idle_mode_t'(phase % 4);
            // The receiver holds off while the sender keeps offering words.
            if (phase == 0) begin
                long_hold_req = 1'b1;
            end
            repeat (PHASE_WORDS) push_word(rand_cycles());
            wait_results();
        end

        repeat (TAIL_CYCLES) @(posedge aclk);
        if (expected_results.size() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, expected_results.size());
        end
        if (mismatch_count == 0 && expected_results.size() == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
sv/dart_pkg.sv
sv/dart_ctrl.sv
sv/dart_dp.sv
sv/divider_and_reload_timer_top.sv
tb/tb_top.sv
